/* sv/adsr_vca_pkg.sv */
package adsr_vca_pkg;

	localparam int SMP_W      = 16;
	localparam int TICK_W     = 24;
	localparam int ELAPSED_W  = 25;
	localparam int LEVEL_W    = 16;
	localparam int QUO_W      = 16;
	localparam int CNT_W      = $clog2(QUO_W);
	localparam int REM_W      = 40;
	localparam int MUL_A_W    = 17;
	localparam int MUL_B_W    = 25;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	localparam logic [LEVEL_W-1:0]   FULL_SCALE  = 16'h8000;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// input word kinds
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd3;

	localparam logic [TICK_W-1:0]  ATTACK_RST  = 24'd4800;
	localparam logic [TICK_W-1:0]  DECAY_RST   = 24'd9600;
	localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd16384;
	localparam logic [TICK_W-1:0]  RELEASE_RST = 24'd12000;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ATTACK_DECAY,
		PH_SUSTAIN,
		PH_RELEASE
	} phase_t;

	typedef enum logic [1:0] {
		SEG_CONST,
		SEG_ATTACK,
		SEG_DECAY,
		SEG_RELEASE
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_LEVEL,
		ST_SCALE_L,
		ST_SCALE_R,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic mul;
		logic div_step;
		logic level;
		logic scale_l;
		logic scale_r;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* sv/adsr_vca_if.sv */
interface adsr_vca_in_if import adsr_vca_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [SMP_W-1:0]  left_in;
	logic signed [SMP_W-1:0]  right_in;

	modport source (output valid, kind, left_in, right_in, input ready);
	modport sink (input valid, kind, left_in, right_in, output ready);
endinterface

interface adsr_vca_out_if import adsr_vca_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SMP_W-1:0]  left_out;
	logic signed [SMP_W-1:0]  right_out;
	logic [LEVEL_W-1:0]       level_out;

	modport source (output valid, left_out, right_out, level_out, input ready);
	modport sink (input valid, left_out, right_out, level_out, output ready);
endinterface

interface adsr_vca_cfg_if import adsr_vca_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_W-1:0]     index;
	logic [CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/adsr_vca_ctrl.sv */
module adsr_vca_ctrl import adsr_vca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] in_kind,
	output logic              in_ready,
	input  sts_t              sts,
	output cmd_t              cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_kind == KIND_TICK) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = sts.need_div ? ST_MUL : ST_SCALE_L;
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				state_d = ST_SCALE_L;
			end
			ST_SCALE_L: begin
				state_d = ST_SCALE_R;
			end
			ST_SCALE_R: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_EVAL:    cmd.eval     = 1'b1;
			ST_MUL:     cmd.mul      = 1'b1;
			ST_DIV:     cmd.div_step = 1'b1;
			ST_LEVEL:   cmd.level    = 1'b1;
			ST_SCALE_L: cmd.scale_l  = 1'b1;
			ST_SCALE_R: cmd.scale_r  = 1'b1;
			ST_EMIT:    cmd.emit     = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* sv/adsr_vca_dp.sv */
module adsr_vca_dp import adsr_vca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [KIND_W-1:0]        in_kind,
	input  logic signed [SMP_W-1:0]  in_left,
	input  logic signed [SMP_W-1:0]  in_right,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SMP_W-1:0]  out_left,
	output logic signed [SMP_W-1:0]  out_right,
	output logic [LEVEL_W-1:0]       out_level
);

	// settings
	logic [TICK_W-1:0]  attack_q, decay_q, release_q;
	logic [LEVEL_W-1:0] sustain_q;

	// envelope state
	phase_t                 phase_q;
	logic [ELAPSED_W-1:0]   elapsed_q;

	// per-tick working registers
	logic signed [SMP_W-1:0] left_q, right_q;
	seg_t                    seg_q;
	logic [LEVEL_W-1:0]      m_q;
	logic [TICK_W-1:0]       x_q;
	logic [TICK_W-1:0]       den_q;
	logic [LEVEL_W-1:0]      level_q;
	logic [REM_W-1:0]        rem_q;
	logic [REM_W-1:0]        dsh_q;
	logic [QUO_W-1:0]        quo_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SMP_W-1:0] scl_l_q, scl_r_q;

	// output register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_left_q, out_right_q;
	logic [LEVEL_W-1:0]      out_level_q;

	// segment decode
	seg_t                 seg_d;
	phase_t               phase_d;
	logic [LEVEL_W-1:0]   m_d;
	logic [TICK_W-1:0]    x_d;
	logic [TICK_W-1:0]    den_d;
	logic [LEVEL_W-1:0]   const_lvl_d;
	logic                 e_lt_a, ema_lt_d, e_lt_r;
	logic [ELAPSED_W-1:0] e_minus_a;

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic                      rem_ge;

	logic [LEVEL_W-1:0] sustain_wr;

	assign sustain_wr = (cfg_data[LEVEL_W-1:0] > FULL_SCALE) ? FULL_SCALE
		: cfg_data[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			sustain_q <= SUSTAIN_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ATTACK:  attack_q  <= cfg_data[TICK_W-1:0];
				REG_DECAY:   decay_q   <= cfg_data[TICK_W-1:0];
				REG_SUSTAIN: sustain_q <= sustain_wr;
				REG_RELEASE: release_q <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign e_lt_a    = elapsed_q < {1'b0, attack_q};
	assign e_minus_a = elapsed_q - {1'b0, attack_q};
	assign ema_lt_d  = e_minus_a < {1'b0, decay_q};
	assign e_lt_r    = elapsed_q < {1'b0, release_q};

	always_comb begin
		seg_d       = SEG_CONST;
		phase_d     = phase_q;
		m_d         = FULL_SCALE;
		x_d         = elapsed_q[TICK_W-1:0];
		den_d       = attack_q;
		const_lvl_d = '0;
		unique case (phase_q)
			PH_ATTACK_DECAY: begin
				if (e_lt_a) begin
					seg_d = SEG_ATTACK;
				end else if (ema_lt_d) begin
					seg_d = SEG_DECAY;
					m_d   = FULL_SCALE - sustain_q;
					x_d   = e_minus_a[TICK_W-1:0];
					den_d = decay_q;
				end else begin
					phase_d     = PH_SUSTAIN;
					const_lvl_d = sustain_q;
				end
			end
			PH_SUSTAIN: begin
				const_lvl_d = sustain_q;
			end
			PH_RELEASE: begin
				if (e_lt_r) begin
					seg_d = SEG_RELEASE;
					m_d   = sustain_q;
					x_d   = release_q - elapsed_q[TICK_W-1:0];
					den_d = release_q;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				const_lvl_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
		end else if (cmd.accept) begin
			if (in_kind == KIND_NOTE_ON) begin
				phase_q   <= PH_ATTACK_DECAY;
				elapsed_q <= '0;
			end else if (in_kind == KIND_NOTE_OFF) begin
				phase_q   <= PH_RELEASE;
				elapsed_q <= '0;
			end
		end else if (cmd.eval) begin
			phase_q <= phase_d;
			if (elapsed_q != ELAPSED_MAX) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (cmd.mul) begin
			mul_a = {1'b0, m_q};
			mul_b = {1'b0, x_q};
		end else if (cmd.scale_r) begin
			mul_a = {1'b0, level_q};
			mul_b = {{(MUL_B_W-SMP_W){right_q[SMP_W-1]}}, right_q};
		end else begin
			mul_a = {1'b0, level_q};
			mul_b = {{(MUL_B_W-SMP_W){left_q[SMP_W-1]}}, left_q};
		end
	end

	assign prod   = mul_a * mul_b;
	assign rem_ge = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && in_kind == KIND_TICK) begin
			left_q  <= in_left;
			right_q <= in_right;
		end
		if (cmd.eval) begin
			seg_q   <= seg_d;
			m_q     <= m_d;
			x_q     <= x_d;
			den_q   <= den_d;
			level_q <= const_lvl_d;
		end
		if (cmd.mul) begin
			rem_q <= prod[REM_W-1:0];
			dsh_q <= {{(REM_W-TICK_W-QUO_W+1){1'b0}}, den_q, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
			cnt_q <= CNT_W'(QUO_W - 1);
		end
		// restoring division, one quotient bit per cycle
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.level) begin
			level_q <= (seg_q == SEG_DECAY) ? (FULL_SCALE - quo_q) : quo_q;
		end
		// arithmetic shift by 15 of the scaled sample
		if (cmd.scale_l) begin
			scl_l_q <= prod[SMP_W+14:15];
		end
		if (cmd.scale_r) begin
			scl_r_q <= prod[SMP_W+14:15];
		end
		if (cmd.emit) begin
			out_left_q  <= scl_l_q;
			out_right_q <= scl_r_q;
			out_level_q <= level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.need_div = seg_d != SEG_CONST;
	assign sts.div_last = cnt_q == '0;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;
	assign out_level = out_level_q;

endmodule

/* sv/adsr_envelope_stereo_vca.sv */
// Linear ADSR envelope driving a stereo VCA.
// din carries one word per event: kind tick (with a left/right sample pair),
// note on or note off. Note words change the envelope phase in the cycle they
// are taken and give no result. Each tick word gives one dout word: both
// samples scaled by the envelope level (arithmetic shift by 15) and the level.
// cfg writes attack, decay, sustain and release settings (indexes 0 to 3); it
// is always ready and is meant to be written while no tick is in flight.
// A tick goes through eval, scale left, scale right and emit while the level
// is constant (idle, sustain); on a ramp, multiply, divide and level steps lie
// between eval and scale left. On a ramp the level comes from a shared
// restoring divider that makes one quotient bit per cycle, after its dividend
// is formed in the shared 17x25 multiplier. One word is worked at a time.
// Note words are handled in the idle state and need no further steps.
// The finished word waits in an output register; din is taken again while it
// waits, but a following tick holds in its last step until dout is free.
// Reset loads the default settings, the idle phase and a zero tick count, and
// clears dout valid.
module adsr_envelope_stereo_vca import adsr_vca_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	adsr_vca_in_if.sink   din,
	adsr_vca_out_if.source dout,
	adsr_vca_cfg_if.sink  cfg
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	adsr_vca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_kind  (din.kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	adsr_vca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (din.kind),
		.in_left   (din.left_in),
		.in_right  (din.right_in),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.out_left  (dout.left_out),
		.out_right (dout.right_out),
		.out_level (dout.level_out)
	);

	assign din.ready = in_ready;
	assign cfg.ready = 1'b1;

`ifndef ASSERT_OFF
	// a result is never written over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!dout.valid || dout.ready))
		else $error("result register overwritten");

	// an accepted tick starts the level evaluation next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.kind == KIND_TICK) |=> cmd.eval)
		else $error("tick accepted without evaluation");

	// no input is taken during the eval, multiply or divide steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.mul || cmd.eval) |-> !din.ready)
		else $error("input taken during computation");

	// the applied level never exceeds full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.level_out <= FULL_SCALE))
		else $error("level above full scale");
`endif

endmodule

/* tb/sv/tb_adsr_envelope_stereo_vca.sv */
module tb_adsr_envelope_stereo_vca import adsr_vca_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 600;
	localparam int PRINT_CAP     = 200;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
	} note_event_t;

	typedef struct {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		logic [LEVEL_W-1:0]      level;
	} vca_word_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	adsr_vca_in_if  din_if();
	adsr_vca_out_if dout_if();
	adsr_vca_cfg_if cfg_if();

	adsr_envelope_stereo_vca u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	always #4 clk = ~clk;

	// envelope state mirrored on the testbench side
	logic [TICK_W-1:0]    atk_len = ATTACK_RST;
	logic [TICK_W-1:0]    dec_len = DECAY_RST;
	logic [LEVEL_W-1:0]   sus_lvl = SUSTAIN_RST;
	logic [TICK_W-1:0]    rel_len = RELEASE_RST;
	phase_t               env_phase = PH_IDLE;
	logic [ELAPSED_W-1:0] tick_count = '0;

	note_event_t event_q[$];
	vca_word_t   scaled_q[$];
	int          mismatches = 0;
	logic        hold_req = 1'b0;
	logic        hold_off = 1'b0;

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [LEVEL_W-1:0] envelope_level();
		logic [63:0] e, s, a, d, r, full;
		full = 64'(FULL_SCALE);
		e = 64'(tick_count);
		s = (sus_lvl > FULL_SCALE) ? full : 64'(sus_lvl);
		a = 64'(atk_len);
		d = 64'(dec_len);
		r = 64'(rel_len);
		case (env_phase)
			PH_ATTACK_DECAY: begin
				if (e < a)
					return LEVEL_W'((e * full) / a);
				if (e - a < d)
					return LEVEL_W'(full - ((full - s) * (e - a)) / d);
				env_phase = PH_SUSTAIN;
				return LEVEL_W'(s);
			end
			PH_SUSTAIN: return LEVEL_W'(s);
			PH_RELEASE: begin
				// release ramps down from sustain, whatever level was reached
				if (e < r)
					return LEVEL_W'((s * (r - e)) / r);
				env_phase = PH_IDLE;
				return '0;
			end
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [SMP_W-1:0] vca_scale(input logic signed [SMP_W-1:0] smp,
			input logic [LEVEL_W-1:0] lvl);
		longint prod;
		prod = longint'(smp) * longint'(lvl);
		return SMP_W'(prod >>> 15);
	endfunction

	task automatic apply_event(input note_event_t ev);
		vca_word_t w;
		logic [LEVEL_W-1:0] lvl;
		case (ev.kind)
			KIND_NOTE_ON: begin
				env_phase = PH_ATTACK_DECAY;
				tick_count = '0;
			end
			KIND_NOTE_OFF: begin
				env_phase = PH_RELEASE;
				tick_count = '0;
			end
			KIND_TICK: begin
				lvl = envelope_level();
				w.left = vca_scale(ev.left, lvl);
				w.right = vca_scale(ev.right, lvl);
				w.level = lvl;
				scaled_q.insert(scaled_q.size(), w);
				if (tick_count != ELAPSED_MAX)
					tick_count++;
			end
			default: ;
		endcase
	endtask

	// sender: bursts of words with random gaps
	note_event_t cur_ev;
	int burst_left = 8;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (din_if.valid && din_if.ready)
				apply_event(cur_ev);
			if (!din_if.valid || din_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					din_if.valid <= 1'b0;
				end else if (event_q.size() != 0) begin
					cur_ev = event_q.pop_front();
					din_if.kind <= cur_ev.kind;
					din_if.left_in <= cur_ev.left;
					din_if.right_in <= cur_ev.right;
					din_if.valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					din_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each word and stalls on its own pattern
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;
	int beat_cnt = 0;

	always @(posedge clk) begin
		vca_word_t w;
		logic rdy;
		if (arst_n) begin
			if (dout_if.valid && dout_if.ready) begin
				if (scaled_q.size() == 0) begin
					flag_mismatch("unexpected word, left", dout_if.left_out, 0);
				end else begin
					w = scaled_q.pop_front();
					if (dout_if.left_out !== w.left)
						flag_mismatch("left_out", dout_if.left_out, w.left);
					if (dout_if.right_out !== w.right)
						flag_mismatch("right_out", dout_if.right_out, w.right);
					if (dout_if.level_out !== w.level)
						flag_mismatch("level_out", dout_if.level_out, w.level);
				end
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 120);
			end
			rx_left--;
			beat_cnt = (beat_cnt == 4) ? 0 : beat_cnt + 1;
			case (rx_mode)
				RX_OPEN:   rdy = 1'b1;
				RX_COIN:   rdy = 1'($urandom_range(0, 1));
				RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
				default:   rdy = (beat_cnt < 3);
			endcase
			dout_if.ready <= rdy && !hold_off;
		end
	end

	// long receiver hold-off so the block backs up into din
	initial begin
		wait (hold_req);
		repeat (40) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// expects to be called just after a rising edge; leaves valid high
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_ATTACK:  atk_len = data;
			REG_DECAY:   dec_len = data;
			REG_SUSTAIN: sus_lvl = data[LEVEL_W-1:0];
			REG_RELEASE: rel_len = data;
			default: ;
		endcase
	endtask

	task automatic push_ev(input logic [KIND_W-1:0] kind, input logic signed [SMP_W-1:0] l,
			input logic signed [SMP_W-1:0] r);
		note_event_t ev;
		ev.kind = kind;
		ev.left = l;
		ev.right = r;
		event_q.insert(event_q.size(), ev);
	endtask

	// wait until every word is out, then give a trailing note time to land
	task automatic drain();
		while (event_q.size() != 0 || din_if.valid || scaled_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return CFG_DATA_W'($urandom);
			3: return 24'd1;
			default: return CFG_DATA_W'($urandom_range(1, 24));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_sustain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_DATA_W'(FULL_SCALE);
			2: return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic queue_ticks(input int n);
		repeat (n) push_ev(KIND_TICK, rand_sample(), rand_sample());
	endtask

	task automatic queue_random_phase(input int n);
		int made;
		int span;
		int k;
		logic [KIND_W-1:0] kind;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) < 8) begin
				push_ev(KIND_NOTE_ON, rand_sample(), rand_sample());
				span = atk_len + dec_len + 8;
				if (span > 40)
					span = 40;
				k = $urandom_range(0, span);
				queue_ticks(k);
				made += k + 1;
				if ($urandom_range(0, 3) != 0) begin
					push_ev(KIND_NOTE_OFF, rand_sample(), rand_sample());
					span = rel_len + 4;
					if (span > 30)
						span = 30;
					k = $urandom_range(0, span);
					queue_ticks(k);
					made += k + 1;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 3))
						0: kind = KIND_TICK;
						1: kind = KIND_NOTE_ON;
						2: kind = KIND_NOTE_OFF;
						default: kind = KIND_UNUSED;
					endcase
					push_ev(kind, rand_sample(), rand_sample());
					if (kind != KIND_UNUSED)
						made++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.kind = KIND_TICK;
		din_if.left_in = '0;
		din_if.right_in = '0;
		dout_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_ATTACK;
		cfg_if.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: idle ticks, unused kind, note off while idle, note on and attack ticks
		push_ev(KIND_TICK, 16'sh7fff, 16'sh8000);
		push_ev(KIND_UNUSED, 16'sh1234, -16'sd1);
		push_ev(KIND_NOTE_OFF, '0, '0);
		push_ev(KIND_TICK, 16'sh8000, 16'sh7fff);
		push_ev(KIND_TICK, 16'sh0000, -16'sd1);
		push_ev(KIND_NOTE_ON, '0, '0);
		push_ev(KIND_TICK, 16'sh7fff, 16'sh8000);
		push_ev(KIND_TICK, -16'sd1, 16'sd1);
		drain();

		// short segments: walk attack, decay, sustain, release, idle
		write_reg(REG_ATTACK, 24'd2);
		write_reg(REG_DECAY, 24'd3);
		write_reg(REG_SUSTAIN, 24'd20000);
		write_reg(REG_RELEASE, 24'd3);
		cfg_if.valid <= 1'b0;
		push_ev(KIND_NOTE_ON, '0, '0);
		repeat (3) push_ev(KIND_TICK, 16'sh7fff, 16'sh8000);
		repeat (3) push_ev(KIND_TICK, 16'sh8000, 16'sh7fff);
		push_ev(KIND_NOTE_OFF, '0, '0);
		repeat (4) push_ev(KIND_TICK, 16'sh7fff, 16'sh8000);
		drain();

		// zero-length segments, sustain over full scale, bogus index
		write_reg(REG_ATTACK, '0);
		write_reg(REG_DECAY, '0);
		write_reg(REG_SUSTAIN, '1);
		write_reg(REG_RELEASE, '0);
		write_reg(8'hff, 24'h5a5a5a);
		cfg_if.valid <= 1'b0;
		push_ev(KIND_NOTE_ON, '0, '0);
		push_ev(KIND_TICK, 16'sh7fff, 16'sh8000);
		push_ev(KIND_NOTE_OFF, '0, '0);
		push_ev(KIND_TICK, 16'sh7fff, 16'sh8000);
		drain();

		// longest segments, sustain at full scale
		write_reg(REG_ATTACK, '1);
		write_reg(REG_DECAY, '1);
		write_reg(REG_SUSTAIN, CFG_DATA_W'(FULL_SCALE));
		write_reg(REG_RELEASE, '1);
		cfg_if.valid <= 1'b0;
		push_ev(KIND_NOTE_ON, '0, '0);
		push_ev(KIND_TICK, 16'sh8000, 16'sh8000);
		push_ev(KIND_NOTE_OFF, '0, '0);
		push_ev(KIND_TICK, 16'sh7fff, 16'sh7fff);
		drain();

		for (int p = 0; p < 8; p++) begin
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
			write_reg(REG_ATTACK, rand_len());
			write_reg(REG_DECAY, rand_len());
			write_reg(REG_SUSTAIN, rand_sustain());
			write_reg(REG_RELEASE, rand_len());
			cfg_if.valid <= 1'b0;
			queue_random_phase(85);
			if (p == 0)
				hold_req = 1'b1;
			drain();
		end

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
